@@ src/arp_cache_with_aging_macros.svh @@
// ---------------------------------------------------------------------------
// ARP cache assertion macros
// Shared property forms for the cache checks, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_AGING_MACROS_SVH
`define ARP_CACHE_WITH_AGING_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/arpc_pkg.sv @@
// ---------------------------------------------------------------------------
// ARP cache package
// Sizes, request codes, controller states and controller/datapath links.
// ---------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_DEPTH = 16;
    localparam int IDX_W       = $clog2(CACHE_DEPTH);
    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int TIME_W      = 32;
    localparam int EXP_W       = 16;

    localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd15;

    typedef logic [1:0] req_t;

    localparam req_t REQ_LEARN  = 2'd0;
    localparam req_t REQ_LOOKUP = 2'd1;
    localparam req_t REQ_AGE    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

@@ src/arpc_ctrl.sv @@
// ---------------------------------------------------------------------------
// ARP cache controller
// Sequences load, a scan over all entries, and a commit for each word.
// ---------------------------------------------------------------------------
module arpc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  arpc_pkg::dp_status_t  status,
    output arpc_pkg::dp_cmd_t     cmd,
    output logic                  busy
);

    arpc_pkg::ctrl_state_t state_reg;
    arpc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = arpc_pkg::ST_SCAN;
                end
            end
            arpc_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = arpc_pkg::ST_COMMIT;
                end
            end
            arpc_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = arpc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/arpc_datapath.sv @@
// ---------------------------------------------------------------------------
// ARP cache datapath
// Entry store, per-entry compare, aging check and result registers.
// ---------------------------------------------------------------------------
module arpc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  arpc_pkg::dp_cmd_t           cmd,
    output arpc_pkg::dp_status_t        status,
    input  logic                        cfg_wr_en,
    input  logic [arpc_pkg::EXP_W-1:0]  cfg_wr_data,
    input  logic [1:0]                  req_type,
    input  logic [arpc_pkg::MAC_W-1:0]  mac_addr,
    input  logic [arpc_pkg::IP_W-1:0]   ip_addr,
    input  logic [arpc_pkg::TIME_W-1:0] now_sec,
    output logic                        done,
    output logic                        hit,
    output logic [arpc_pkg::MAC_W-1:0]  found_mac,
    output logic                        learned_new,
    output logic                        table_full
);

    localparam int DEPTH = arpc_pkg::CACHE_DEPTH;
    localparam int IW    = arpc_pkg::IDX_W;

    logic [arpc_pkg::EXP_W-1:0]  expiry_reg;
    arpc_pkg::req_t              req_reg;
    logic [arpc_pkg::MAC_W-1:0]  mac_reg;
    logic [arpc_pkg::IP_W-1:0]   ip_reg;
    logic [arpc_pkg::TIME_W-1:0] now_reg;
    logic [IW-1:0]               idx_reg;

    logic [DEPTH-1:0]            used_reg;
    logic [DEPTH-1:0]            alive_reg;

    logic [arpc_pkg::MAC_W-1:0]  mem_mac  [DEPTH];
    logic [arpc_pkg::IP_W-1:0]   mem_ip   [DEPTH];
    logic [arpc_pkg::TIME_W-1:0] mem_time [DEPTH];

    logic [arpc_pkg::MAC_W-1:0]  rd_mac_reg;
    logic [arpc_pkg::IP_W-1:0]   rd_ip_reg;
    logic [arpc_pkg::TIME_W-1:0] rd_time_reg;

    logic                        matched_reg;
    logic                        free_found_reg;
    logic [IW-1:0]               free_idx_reg;
    logic                        hit_reg;
    logic [arpc_pkg::MAC_W-1:0]  found_reg;
    logic                        learned_reg;
    logic                        full_reg;
    logic                        done_reg;

    logic [IW-1:0]               rd_addr;
    logic [IW-1:0]               wr_time_addr;
    logic [arpc_pkg::TIME_W-1:0] age;
    logic                        ent_used;
    logic                        ent_alive;
    logic                        is_learn;
    logic                        is_lookup;
    logic                        is_age;
    logic                        refresh;
    logic                        take_free;
    logic                        lookup_hit;
    logic                        age_kill;
    logic                        insert;
    logic                        full_set;
    logic                        wr_time_en;

    // Read one entry ahead of the compare index.
    assign rd_addr   = cmd.scan ? idx_reg + 1'b1 : '0;
    assign ent_used  = used_reg[idx_reg];
    assign ent_alive = alive_reg[idx_reg];
    assign age       = now_reg - rd_time_reg;

    assign is_learn  = (req_reg == arpc_pkg::REQ_LEARN);
    assign is_lookup = (req_reg == arpc_pkg::REQ_LOOKUP);
    assign is_age    = (req_reg == arpc_pkg::REQ_AGE);

    assign refresh    = cmd.scan && is_learn && ent_used && (rd_mac_reg == mac_reg);
    assign take_free  = cmd.scan && is_learn && !ent_used && !free_found_reg;
    assign lookup_hit = cmd.scan && is_lookup && ent_used && ent_alive
                        && (rd_ip_reg == ip_reg) && !hit_reg;
    assign age_kill   = cmd.scan && is_age && ent_used && ent_alive
                        && (age >= arpc_pkg::TIME_W'(expiry_reg));
    assign insert     = cmd.commit && is_learn && !matched_reg && free_found_reg;
    assign full_set   = cmd.commit && is_learn && !matched_reg && !free_found_reg;

    assign wr_time_en   = refresh || insert;
    assign wr_time_addr = insert ? free_idx_reg : idx_reg;

    assign status.scan_last = (idx_reg == IW'(DEPTH - 1));

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign found_mac   = found_reg;
    assign learned_new = learned_reg;
    assign table_full  = full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= arpc_pkg::EXPIRY_RESET;
        end
        else if (cfg_wr_en)
        begin
            expiry_reg <= cfg_wr_data;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            mac_reg <= mac_addr;
            ip_reg  <= ip_addr;
            now_reg <= now_sec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            matched_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            found_reg      <= '0;
            learned_reg    <= 1'b0;
            full_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.load)
            begin
                idx_reg        <= '0;
                matched_reg    <= 1'b0;
                free_found_reg <= 1'b0;
                hit_reg        <= 1'b0;
                found_reg      <= '0;
                learned_reg    <= 1'b0;
                full_reg       <= 1'b0;
            end
            if (cmd.scan)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (refresh)
            begin
                matched_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (lookup_hit)
            begin
                hit_reg   <= 1'b1;
                found_reg <= rd_mac_reg;
            end
            if (insert)
            begin
                learned_reg <= 1'b1;
            end
            if (full_set)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    // Entry flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            alive_reg <= '0;
        end
        else
        begin
            if (refresh)
            begin
                alive_reg[idx_reg] <= 1'b1;
            end
            if (age_kill)
            begin
                alive_reg[idx_reg] <= 1'b0;
            end
            if (insert)
            begin
                used_reg[free_idx_reg]  <= 1'b1;
                alive_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    // Entry store: registered read, one write address per field.
    always_ff @(posedge clk)
    begin
        if (wr_time_en)
        begin
            mem_time[wr_time_addr] <= now_reg;
        end
        if (insert)
        begin
            mem_mac[free_idx_reg] <= mac_reg;
            mem_ip[free_idx_reg]  <= ip_reg;
        end
        rd_mac_reg  <= mem_mac[rd_addr];
        rd_ip_reg   <= mem_ip[rd_addr];
        rd_time_reg <= mem_time[rd_addr];
    end

endmodule

@@ src/arp_cache_with_aging.sv @@
// ---------------------------------------------------------------------------
// ARP cache with aging: an accepted word is scanned over all 16 entries, one entry per cycle,
// then committed; the done strobe is registered from the commit state and is up in the idle
// state that follows, which also accepts the next word. A new word is not taken while one
// is still in the scan or commit state.
// Reset clears all used and alive flags at once and sets expiry to 15; the receiver cannot stall.
// ---------------------------------------------------------------------------
`include "arp_cache_with_aging_macros.svh"

module arp_cache_with_aging (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [arpc_pkg::MAC_W-1:0]  mac_addr,
    input  logic [arpc_pkg::IP_W-1:0]   ip_addr,
    input  logic [arpc_pkg::TIME_W-1:0] now_sec,
    // expiry register write
    input  logic                        cfg_wr_en,
    input  logic [arpc_pkg::EXP_W-1:0]  cfg_wr_data,
    // result channel
    output logic                        done,
    output logic                        hit,
    output logic [arpc_pkg::MAC_W-1:0]  found_mac,
    output logic                        learned_new,
    output logic                        table_full
);

    // Command and status between the sequencer and the entry datapath.
    arpc_pkg::dp_cmd_t    cmd;
    arpc_pkg::dp_status_t status;

    // Outcome flags of a result word agree with each other.
    logic                 result_consistent;

    // The controller walks each word through three phases:
    //   load   - capture the request and prefetch entry 0
    //   scan   - compare one entry per cycle while prefetching the next;
    //            refresh matching MACs, note the first free slot, catch the
    //            first live IP match, or drop expired entries
    //   commit - insert a new pair into the free slot or flag a full table
    // The result registers are strobed out the cycle after commit, which is
    // also the first cycle a new word can be accepted.
    arpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Entry store, flags, compare logic and result registers.
    arpc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req_type),
        .mac_addr    (mac_addr),
        .ip_addr     (ip_addr),
        .now_sec     (now_sec),
        .done        (done),
        .hit         (hit),
        .found_mac   (found_mac),
        .learned_new (learned_new),
        .table_full  (table_full)
    );

    // At most one outcome flag per result; a miss carries a zero MAC.
    assign result_consistent = $onehot0({hit, learned_new, table_full})
                               && (hit || found_mac == '0);

    // Results come out only once the sequencer is back to idle.
    `ARPC_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
    // Every commit reports in the cycle after it.
    `ARPC_ASSERT_NEXT(a_commit_done, cmd.commit, done, "commit without result strobe")
    // A word accepted moves the sequencer out of idle.
    `ARPC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word left block idle")
    // Hold the outcome flags consistent on every result word.
    `ARPC_ASSERT_NOW(a_one_outcome, done, result_consistent, "inconsistent result flags")

endmodule

@@ sim/tb_arp_cache_with_aging.sv @@
// ---------------------------------------------------------------------------
// ARP cache with aging testbench
// Walks a directed table of learn, lookup and age words, then random traffic
// over a small pool of MAC and IP addresses in several expiry settings and
// sender idle patterns. Every result word is checked against a cycle-free
// shadow copy of the cache or, for a typed directed row, the row's own result.
// ---------------------------------------------------------------------------
module tb_arp_cache_with_aging;

    localparam int                                CACHE_DEPTH  = arpc_pkg::CACHE_DEPTH;
    localparam int                                MAC_W        = arpc_pkg::MAC_W;
    localparam int                                IP_W         = arpc_pkg::IP_W;
    localparam int                                TIME_W       = arpc_pkg::TIME_W;
    localparam int                                EXP_W        = arpc_pkg::EXP_W;
    localparam logic [arpc_pkg::EXP_W-1:0]        EXPIRY_RESET = arpc_pkg::EXPIRY_RESET;

    localparam arpc_pkg::req_t REQ_LEARN  = arpc_pkg::REQ_LEARN;
    localparam arpc_pkg::req_t REQ_LOOKUP = arpc_pkg::REQ_LOOKUP;
    localparam arpc_pkg::req_t REQ_AGE    = arpc_pkg::REQ_AGE;

    // Request code the block must ignore: no state change, all-zero result.
    localparam arpc_pkg::req_t REQ_UNKNOWN = 2'd3;

    localparam logic [MAC_W-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [IP_W-1:0]  IP_ONES  = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0] MAC_A    = 48'h0002_A1B2_C3D4;
    localparam logic [MAC_W-1:0] MAC_B    = 48'h0002_55AA_0F0F;
    localparam logic [IP_W-1:0]  IP_NET   = 32'h0A00_0001;
    localparam logic [IP_W-1:0]  IP_OTHER = 32'h1234_5678;

    localparam int MAC_POOL  = 24;
    localparam int IP_POOL   = 20;
    localparam int PHASE_LEN = 285;
    localparam int GAP_MAX   = 60;
    localparam int DRAIN     = 40;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] found_mac;
        logic             learned_new;
        logic             table_full;
    } arp_result_t;

    localparam arp_result_t MISS     = '0;
    localparam arp_result_t FRESH    = '{hit: 1'b0, found_mac: 48'h0,
                                         learned_new: 1'b1, table_full: 1'b0};
    localparam arp_result_t HIT_ZERO = '{hit: 1'b1, found_mac: 48'h0,
                                         learned_new: 1'b0, table_full: 1'b0};
    localparam arp_result_t HIT_ONES = '{hit: 1'b1, found_mac: MAC_ONES,
                                         learned_new: 1'b0, table_full: 1'b0};
    localparam arp_result_t HIT_A    = '{hit: 1'b1, found_mac: MAC_A,
                                         learned_new: 1'b0, table_full: 1'b0};
    localparam arp_result_t HIT_B    = '{hit: 1'b1, found_mac: MAC_B,
                                         learned_new: 1'b0, table_full: 1'b0};

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // One directed step: either a request word or an expiry write. Where
    // typed is set, the result is taken from the row instead of the shadow.
    typedef struct packed {
        row_kind_t         kind;
        logic [EXP_W-1:0]  expiry;
        arpc_pkg::req_t    req;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] now;
        logic              typed;
        arp_result_t       res;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          req_type;
    logic [MAC_W-1:0]    mac_addr;
    logic [IP_W-1:0]     ip_addr;
    logic [TIME_W-1:0]   now_sec;
    logic                cfg_wr_en;
    logic [EXP_W-1:0]    cfg_wr_data;
    logic                done;
    logic                hit;
    logic [MAC_W-1:0]    found_mac;
    logic                learned_new;
    logic                table_full;

    // Typed expectation travels with the word, driven like a request field.
    logic                typed_chk;
    arp_result_t         typed_res;

    // Shadow cache and expiry register.
    logic                slot_used  [CACHE_DEPTH];
    logic                slot_alive [CACHE_DEPTH];
    logic [MAC_W-1:0]    slot_mac   [CACHE_DEPTH];
    logic [IP_W-1:0]     slot_ip    [CACHE_DEPTH];
    logic [TIME_W-1:0]   slot_stamp [CACHE_DEPTH];
    logic [EXP_W-1:0]    expiry_now;

    arp_result_t         pending_results [$];
    int                  fail_count = 0;

    dir_row_t            dir_rows [0:25];

    arp_cache_with_aging uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .mac_addr    (mac_addr),
        .ip_addr     (ip_addr),
        .now_sec     (now_sec),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .hit         (hit),
        .found_mac   (found_mac),
        .learned_new (learned_new),
        .table_full  (table_full)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request to the shadow cache and produce its result word.
    task automatic resolve_request(input arpc_pkg::req_t rq, input logic [MAC_W-1:0] m,
                                   input logic [IP_W-1:0] ip,
                                   input logic [TIME_W-1:0] t,
                                   output arp_result_t res);
        logic              matched;
        int                free_slot;
        logic [TIME_W-1:0] age;
        res       = '0;
        matched   = 1'b0;
        free_slot = -1;
        case (rq)
            REQ_LEARN:
            begin
                // Refresh every used entry with this MAC; the stored IP stays.
                for (int i = 0; i < CACHE_DEPTH; i++)
                begin
                    if (slot_used[i])
                    begin
                        if (slot_mac[i] == m)
                        begin
                            slot_stamp[i] = t;
                            slot_alive[i] = 1'b1;
                            matched       = 1'b1;
                        end
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
                if (!matched)
                begin
                    if (free_slot >= 0)
                    begin
                        slot_used[free_slot]  = 1'b1;
                        slot_alive[free_slot] = 1'b1;
                        slot_mac[free_slot]   = m;
                        slot_ip[free_slot]    = ip;
                        slot_stamp[free_slot] = t;
                        res.learned_new       = 1'b1;
                    end
                    else
                        res.table_full = 1'b1;
                end
            end
            REQ_LOOKUP:
            begin
                // Lowest-index alive match wins; dead entries are skipped.
                for (int i = 0; i < CACHE_DEPTH; i++)
                begin
                    if (!res.hit && slot_used[i] && slot_alive[i] && slot_ip[i] == ip)
                    begin
                        res.hit       = 1'b1;
                        res.found_mac = slot_mac[i];
                    end
                end
            end
            REQ_AGE:
            begin
                // Age wraps modulo 2^32, so a clock that went back looks very old.
                for (int i = 0; i < CACHE_DEPTH; i++)
                begin
                    if (slot_used[i] && slot_alive[i])
                    begin
                        age = t - slot_stamp[i];
                        if (age >= {16'h0, expiry_now})
                            slot_alive[i] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string field, input logic [MAC_W-1:0] want,
                                 input logic [MAC_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endtask

    // Track accepted words and expiry writes, then check each done strobe
    // against the oldest outstanding expectation. Sample everything at the
    // edge, so the values seen are the ones the block sees.
    always @(posedge clk)
    begin : result_monitor
        arp_result_t predicted;
        arp_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_DEPTH; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_alive[i] = 1'b0;
            end
            expiry_now = EXPIRY_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                expiry_now = cfg_wr_data;
            if (start && !busy)
            begin
                resolve_request(req_type, mac_addr, ip_addr, now_sec, predicted);
                pending_results.push_back(typed_chk ? typed_res : predicted);
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none actual %0b %h %0b %0b",
                             $time, hit, found_mac, learned_new, table_full);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (hit !== want.hit)
                        note_mismatch("hit", MAC_W'(want.hit), MAC_W'(hit));
                    if (found_mac !== want.found_mac)
                        note_mismatch("found_mac", want.found_mac, found_mac);
                    if (learned_new !== want.learned_new)
                        note_mismatch("learned_new", MAC_W'(want.learned_new),
                                      MAC_W'(learned_new));
                    if (table_full !== want.table_full)
                        note_mismatch("table_full", MAC_W'(want.table_full),
                                      MAC_W'(table_full));
                end
            end
        end
    end

    // Present one word after an optional idle gap and hold it until accepted.
    // Leave start high afterwards so the next word can follow back to back.
    task automatic send_word(input arpc_pkg::req_t rq, input logic [MAC_W-1:0] m,
                             input logic [IP_W-1:0] ip, input logic [TIME_W-1:0] t,
                             input logic chk, input arp_result_t res, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= rq;
        mac_addr  <= m;
        ip_addr   <= ip;
        now_sec   <= t;
        typed_chk <= chk;
        typed_res <= res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start, drain every outstanding result, then write the expiry.
    task automatic load_expiry(input logic [EXP_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [MAC_W-1:0]  mac_pool [MAC_POOL];
        logic [IP_W-1:0]   ip_pool  [IP_POOL];
        logic [TIME_W-1:0] clock_sec;
        logic [MAC_W-1:0]  m;
        logic [IP_W-1:0]   ip;
        logic [EXP_W-1:0]  phase_expiry;
        arpc_pkg::req_t    rq;
        int                idle_pct;
        int                r;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        req_type    <= REQ_LEARN;
        mac_addr    <= '0;
        ip_addr     <= '0;
        now_sec     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        typed_chk   <= 1'b0;
        typed_res   <= '0;

        // Expiry is 15 out of reset. Slots fill 0, 1, 2, 3 in order below.
        dir_rows = '{
            // empty cache: lookup misses, age does nothing, unknown is ignored
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    32'h0,    32'h0,    1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_AGE,     48'h0,    32'h0,    32'h0,    1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_UNKNOWN, MAC_ONES, IP_ONES,  IP_ONES,  1'b1, MISS},
            // field extremes, both learned fresh
            '{ROW_WORD, 16'd0, REQ_LEARN,   48'h0,    32'h0,    32'h0,    1'b1, FRESH},
            '{ROW_WORD, 16'd0, REQ_LEARN,   MAC_ONES, IP_ONES,  IP_ONES,  1'b1, FRESH},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    IP_ONES,  32'h0,    1'b1, HIT_ONES},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    32'h0,    32'h0,    1'b1, HIT_ZERO},
            // refresh keeps the old IP, so the new one is not found
            '{ROW_WORD, 16'd0, REQ_LEARN,   MAC_ONES, IP_OTHER, 32'd5,    1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    IP_OTHER, 32'd5,    1'b1, MISS},
            // two entries on one IP: lowest index answers
            '{ROW_WORD, 16'd0, REQ_LEARN,   MAC_A,    IP_NET,   32'd10,   1'b1, FRESH},
            '{ROW_WORD, 16'd0, REQ_LEARN,   MAC_B,    IP_NET,   32'd10,   1'b1, FRESH},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    IP_NET,   32'd10,   1'b1, HIT_A},
            // age at 20: slot 0 (20 old) and slot 1 (exactly 15 old) die
            '{ROW_WORD, 16'd0, REQ_AGE,     48'h0,    32'h0,    32'd20,   1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    32'h0,    32'd20,   1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    IP_ONES,  32'd20,   1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    IP_NET,   32'd20,   1'b1, HIT_A},
            // learn revives a dead entry
            '{ROW_WORD, 16'd0, REQ_LEARN,   48'h0,    32'h99,   32'd21,   1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    32'h0,    32'd21,   1'b1, HIT_ZERO},
            // clock went back by one: wrapped age is huge, slot 0 dies again
            '{ROW_WORD, 16'd0, REQ_AGE,     48'h0,    32'h0,    32'd20,   1'b1, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    32'h0,    32'd20,   1'b1, MISS},
            // zero expiry kills every alive entry
            '{ROW_CFG,  16'd0, REQ_LEARN,   48'h0,    32'h0,    32'h0,    1'b0, MISS},
            '{ROW_WORD, 16'd0, REQ_AGE,     48'h0,    32'h0,    32'd10,   1'b0, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    IP_NET,   32'd10,   1'b1, MISS},
            '{ROW_CFG,  16'hFFFF, REQ_LEARN, 48'h0,   32'h0,    32'h0,    1'b0, MISS},
            '{ROW_WORD, 16'd0, REQ_LEARN,   MAC_B,    32'h7,    32'd100,  1'b0, MISS},
            '{ROW_WORD, 16'd0, REQ_LOOKUP,  48'h0,    IP_NET,   32'd100,  1'b1, HIT_B}
        };

        for (int i = 0; i < MAC_POOL; i++)
            mac_pool[i] = {16'($urandom), $urandom};
        for (int i = 0; i < IP_POOL; i++)
            ip_pool[i] = $urandom;
        clock_sec = $urandom;

        // Hold reset, then release it and never assert it again.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
                load_expiry(dir_rows[k].expiry);
            else
                send_word(dir_rows[k].req, dir_rows[k].mac, dir_rows[k].ip,
                          dir_rows[k].now, dir_rows[k].typed, dir_rows[k].res, 0);
        end

        // Random traffic. Phases: no idling, sender mostly idle, receiver
        // stalling (it cannot hold results off, so this runs like no idling),
        // and a lightly idle sender. Each phase gets its own expiry.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin phase_expiry = 16'hFFFF;                   idle_pct = 0;  end
                1:       begin phase_expiry = 16'd1;                      idle_pct = 88; end
                2:       begin phase_expiry = 16'($urandom_range(2, 60)); idle_pct = 0;  end
                default: begin phase_expiry = 16'($urandom);              idle_pct = 13; end
            endcase
            load_expiry(phase_expiry);

            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // Advance the clock mostly in small steps, sometimes jump
                // anywhere so the age wraps or exceeds any expiry.
                r = $urandom_range(99);
                if (r < 88)
                    clock_sec = clock_sec + $urandom_range(0, 3);
                else if (r < 97)
                    clock_sec = clock_sec + $urandom_range(0, 80);
                else
                    clock_sec = $urandom;

                m  = (($urandom_range(99) < 90) ? mac_pool[$urandom_range(MAC_POOL - 1)]
                                               : {16'($urandom), $urandom});
                ip = (($urandom_range(99) < 85) ? ip_pool[$urandom_range(IP_POOL - 1)]
                                               : $urandom);
                r = $urandom_range(99);
                if (r < 40)
                    rq = REQ_LEARN;
                else if (r < 75)
                    rq = REQ_LOOKUP;
                else if (r < 95)
                    rq = REQ_AGE;
                else
                    rq = REQ_UNKNOWN;

                send_word(rq, m, ip, clock_sec, 1'b0, MISS, idle_pct);
            end
        end

        // Drain outstanding results, then keep watching for any stray strobe.
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/arpc_pkg.sv
src/arpc_ctrl.sv
src/arpc_datapath.sv
src/arp_cache_with_aging.sv
sim/tb_arp_cache_with_aging.sv
